// ----- hdl/apq_rle_pkg.sv -----
// Package for the adaptive palette quantizer with run-length coding.
// Holds field widths, distance constants, result kinds, CSR indexes and shared types.
// No dependencies.
package apq_rle_pkg;

   // defaults for the top-level parameters
   localparam int DEF_PALETTE_DEPTH   = 128;
   localparam int DEF_RUN_LENGTH_BITS = 24;

   // fixed field widths
   localparam int PIXEL_W  = 32;
   localparam int KIND_W   = 2;
   localparam int INDEX_W  = 7;
   localparam int LENGTH_W = 24;
   localparam int THRESH_W = 17;
   localparam int MAXC_W   = 8;
   localparam int RSP_DATA_W = 64;

   // reset values of the configuration registers
   localparam logic [THRESH_W-1:0] THRESH_RESET = 17'd1000;
   localparam logic [MAXC_W-1:0]   MAXC_RESET   = 8'd99;

   // distance: S = sum(w * d^2), dist = floor(S / 100)
   localparam int SQ_W    = 16;
   localparam int SUM_W   = 23;
   localparam int DIST_W  = 17;
   localparam int BEST_W  = 24;
   localparam logic [5:0] WEIGHT [4] = '{6'd11, 6'd59, 6'd30, 6'd10};
   // floor(S/100) = (S * RECIP) >> DIV_SHIFT, exact for S < 2^23
   localparam int DIV_SHIFT = 30;
   localparam int PROD_W    = 47;
   localparam logic [23:0] RECIP = 24'd10737419;
   localparam logic [BEST_W-1:0] START_DIST = 24'd10000000;

   typedef enum logic [KIND_W-1:0] {
      KIND_RUN      = 2'd0,
      KIND_ENTRY    = 2'd1,
      KIND_OVERFLOW = 2'd2
   } kind_type;

   typedef enum logic {
      CSR_THRESHOLD  = 1'b0,
      CSR_MAX_COLORS = 1'b1
   } csr_index_type;

   typedef struct packed {
      kind_type              kind;
      logic [INDEX_W-1:0]    index;
      logic [LENGTH_W-1:0]   length;
      logic [PIXEL_W-1:0]    color;
      logic                  last;
   } result_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_DRAIN  = 5'b00100,
      ST_DECIDE = 5'b01000,
      ST_EMIT   = 5'b10000
   } state_type;

endpackage

// ----- hdl/adaptive_palette_quantizer_rle_unit.sv -----
// Steps of a request: palette reads, four distance stages, drain, decide, output load; with
// an empty palette it goes straight to decide, and while the overflow error holds straight to
// the output load. A new request is taken only once every result of the last one is loaded,
// so requests are handled one at a time.
// The last result of a request may wait in the output register while the next scans.
// Reset (synchronous, active high) empties palette and run state, restores CSR defaults.
module adaptive_palette_quantizer_rle_unit #(
   parameter int PALETTE_DEPTH   = apq_rle_pkg::DEF_PALETTE_DEPTH,
   parameter int RUN_LENGTH_BITS = apq_rle_pkg::DEF_RUN_LENGTH_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [apq_rle_pkg::PIXEL_W-1:0]       req_tdata,   // pixel_color
   input  logic                                  req_tlast,   // pixel_last
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // color_index [6:0], run_length [30:7], entry_color [62:31], zero [63]
   output logic [apq_rle_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [apq_rle_pkg::KIND_W-1:0]        rsp_tuser,   // result_kind
   output logic                                  rsp_tlast,   // result_last
   input  logic                                  csr_we,
   input  logic                                  csr_addr,
   input  logic [apq_rle_pkg::THRESH_W-1:0]      csr_wdata
);
   import apq_rle_pkg::*;

   localparam int IDX_W = $clog2(PALETTE_DEPTH);
   localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);
   localparam int RL_W  = RUN_LENGTH_BITS;

   // configuration
   logic [THRESH_W-1:0] thresh_ff;
   logic [MAXC_W-1:0]   maxc_ff;

   // control
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   issue_ff, issue_in;
   logic               ovf_seen_ff, ovf_seen_in;
   logic [INDEX_W-1:0] run_idx_ff, run_idx_in;
   logic [RL_W-1:0]    run_len_ff, run_len_in;
   logic [1:0]         res_n_ff, res_n_in;
   logic [1:0]         res_ptr_ff, res_ptr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               v_rd_ff, v_s1_ff, v_s2_ff, v_s3_ff, v_s4_ff;

   // payload
   logic [PIXEL_W-1:0] pix_ff;
   logic               last_ff;
   logic [BEST_W-1:0]  best_ff;
   logic [IDX_W-1:0]   best_idx_ff;
   result_type         res_q_ff [3];
   result_type         out_ff;

   // palette memory
   logic [PIXEL_W-1:0] palette_mem [PALETTE_DEPTH];
   logic [PIXEL_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]   rd_addr;
   logic               mem_we;

   // distance pipeline
   logic [IDX_W-1:0]   rd_idx_ff, s1_idx_ff, s2_idx_ff, s3_idx_ff, s4_idx_ff;
   logic [SQ_W-1:0]    sq_ff  [4];
   logic [SUM_W-1:0]   wt_ff  [4];
   logic [SUM_W-1:0]   sum_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [DIST_W-1:0]  cand_dist;

   // decision
   logic               accept;
   logic               load_out;
   logic               new_entry;
   logic               overflow_now;
   logic [31:0]        limit;
   logic [IDX_W-1:0]   idx_final;
   logic               extend;
   logic [INDEX_W-1:0] run_idx_next;
   logic [RL_W-1:0]    run_len_next;
   result_type         list [3];
   logic [1:0]         list_n;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign load_out   = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, out_ff.color, out_ff.length, out_ff.index};
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_ff.last;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
         maxc_ff   <= MAXC_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_THRESHOLD:  thresh_ff <= csr_wdata;
            CSR_MAX_COLORS: maxc_ff   <= csr_wdata[MAXC_W-1:0];
            default: ;
         endcase
      end
   end

   // palette memory: one write port, one registered read port
   assign rd_addr = issue_ff[IDX_W-1:0];
   assign mem_we  = (state_ff == ST_DECIDE) && new_entry && !overflow_now;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         palette_mem[count_ff[IDX_W-1:0]] <= pix_ff;
      end
      rd_data_ff <= palette_mem[rd_addr];
   end

   // distance pipeline: square, weight, sum, reciprocal multiply
   always_ff @(posedge clock) begin
      for (int c = 0; c < 4; c++) begin
         logic [7:0] a, b, d;
         a = pix_ff[8*c +: 8];
         b = rd_data_ff[8*c +: 8];
         d = (a > b) ? (a - b) : (b - a);
         sq_ff[c] <= SQ_W'(d) * SQ_W'(d);
         wt_ff[c] <= SUM_W'(WEIGHT[c]) * SUM_W'(sq_ff[c]);
      end
      sum_ff    <= wt_ff[0] + wt_ff[1] + wt_ff[2] + wt_ff[3];
      prod_ff   <= PROD_W'(sum_ff) * PROD_W'(RECIP);
      rd_idx_ff <= rd_addr;
      s1_idx_ff <= rd_idx_ff;
      s2_idx_ff <= s1_idx_ff;
      s3_idx_ff <= s2_idx_ff;
      s4_idx_ff <= s3_idx_ff;
   end

   assign cand_dist = prod_ff[DIV_SHIFT +: DIST_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_rd_ff <= 1'b0;
         v_s1_ff <= 1'b0;
         v_s2_ff <= 1'b0;
         v_s3_ff <= 1'b0;
         v_s4_ff <= 1'b0;
      end else begin
         v_rd_ff <= (state_ff == ST_SCAN);
         v_s1_ff <= v_rd_ff;
         v_s2_ff <= v_s1_ff;
         v_s3_ff <= v_s2_ff;
         v_s4_ff <= v_s3_ff;
      end
   end

   // best match; ties go to the later entry
   always_ff @(posedge clock) begin
      if (accept) begin
         pix_ff      <= req_tdata;
         last_ff     <= req_tlast;
         best_ff     <= START_DIST;
         best_idx_ff <= '0;
      end else if (v_s4_ff && (BEST_W'(cand_dist) <= best_ff)) begin
         best_ff     <= BEST_W'(cand_dist);
         best_idx_ff <= s4_idx_ff;
      end
   end

   // decision and result list
   always_comb begin
      limit        = (32'(maxc_ff) < 32'(PALETTE_DEPTH)) ? 32'(maxc_ff) : 32'(PALETTE_DEPTH);
      new_entry    = (best_ff >= BEST_W'(thresh_ff));
      overflow_now = new_entry && ((32'(count_ff) + 32'd1) > limit);
      idx_final    = new_entry ? count_ff[IDX_W-1:0] : best_idx_ff;
      extend       = (run_len_ff != '0) && (32'(idx_final) == 32'(run_idx_ff)) &&
                     (run_len_ff != '1);
      run_idx_next = extend ? run_idx_ff : INDEX_W'(idx_final);
      run_len_next = extend ? (run_len_ff + RL_W'(1)) : RL_W'(1);
      list_n       = 2'd0;
      for (int k = 0; k < 3; k++) begin
         list[k] = '0;
      end
      if (overflow_now) begin
         list[0].kind = KIND_OVERFLOW;
         list_n       = 2'd1;
      end else begin
         if (new_entry) begin
            list[list_n].kind  = KIND_ENTRY;
            list[list_n].index = INDEX_W'(idx_final);
            list[list_n].color = pix_ff;
            list_n             = list_n + 2'd1;
         end
         if (!extend && (run_len_ff != '0)) begin
            list[list_n].kind   = KIND_RUN;
            list[list_n].index  = run_idx_ff;
            list[list_n].length = LENGTH_W'(run_len_ff);
            list_n              = list_n + 2'd1;
         end
         if (last_ff) begin
            list[list_n].kind   = KIND_RUN;
            list[list_n].index  = run_idx_next;
            list[list_n].length = LENGTH_W'(run_len_next);
            list_n              = list_n + 2'd1;
         end
      end
      if (list_n != 2'd0) begin
         list[list_n - 2'd1].last = 1'b1;
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      issue_in     = issue_ff;
      ovf_seen_in  = ovf_seen_ff;
      run_idx_in   = run_idx_ff;
      run_len_in   = run_len_ff;
      res_n_in     = res_n_ff;
      res_ptr_in   = res_ptr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               issue_in   = '0;
               res_ptr_in = 2'd0;
               if (ovf_seen_ff) begin
                  res_n_in = 2'd1;
                  state_in = ST_EMIT;
               end else if (count_ff == '0) begin
                  state_in = ST_DECIDE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (issue_ff == count_ff - CNT_W'(1)) begin
               state_in = ST_DRAIN;
            end else begin
               issue_in = issue_ff + CNT_W'(1);
            end
         end
         ST_DRAIN: begin
            if (!(v_rd_ff || v_s1_ff || v_s2_ff || v_s3_ff || v_s4_ff)) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            res_n_in   = list_n;
            res_ptr_in = 2'd0;
            if (overflow_now) begin
               ovf_seen_in = 1'b1;
            end else begin
               if (new_entry) begin
                  count_in = count_ff + CNT_W'(1);
               end
               run_idx_in = run_idx_next;
               run_len_in = last_ff ? '0 : run_len_next;
            end
            state_in = (list_n != 2'd0) ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (load_out) begin
               rsp_valid_in = 1'b1;
               res_ptr_in   = res_ptr_ff + 2'd1;
               if (res_ptr_ff == res_n_ff - 2'd1) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         issue_ff     <= '0;
         ovf_seen_ff  <= 1'b0;
         run_idx_ff   <= '0;
         run_len_ff   <= '0;
         res_n_ff     <= 2'd0;
         res_ptr_ff   <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         ovf_seen_ff  <= ovf_seen_in;
         run_idx_ff   <= run_idx_in;
         run_len_ff   <= run_len_in;
         res_n_ff     <= res_n_in;
         res_ptr_ff   <= res_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // pending results and output register
   always_ff @(posedge clock) begin
      if (accept && ovf_seen_ff) begin
         res_q_ff[0] <= '{kind: KIND_OVERFLOW, index: '0, length: '0, color: '0,
                          last: 1'b1};
      end else if (state_ff == ST_DECIDE) begin
         for (int k = 0; k < 3; k++) begin
            res_q_ff[k] <= list[k];
         end
      end
      if (load_out) begin
         out_ff <= res_q_ff[res_ptr_ff];
      end
   end

endmodule

// ----- tb/apq_rle_checker.sv -----
// Checker for the adaptive palette quantizer with run-length coding.
// Watches the request, result and CSR channels, predicts each result and compares.
// Depends on apq_rle_pkg for field widths, result kinds and CSR indexes.
module apq_rle_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [apq_rle_pkg::PIXEL_W-1:0]    req_tdata,
   input  logic                               req_tlast,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [apq_rle_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic [apq_rle_pkg::KIND_W-1:0]     rsp_tuser,
   input  logic                               rsp_tlast,
   input  logic                               csr_we,
   input  logic                               csr_addr,
   input  logic [apq_rle_pkg::THRESH_W-1:0]   csr_wdata,
   output int                                 fail_count,
   output int                                 pending_results,
   output int                                 palette_size
);
   timeunit 1ns;
   timeprecision 1ps;
   import apq_rle_pkg::*;

   localparam int DEPTH = DEF_PALETTE_DEPTH;
   localparam int unsigned FAR_DISTANCE = 10000000;
   localparam logic [LENGTH_W-1:0] RUN_MAX = '1;
   localparam int unsigned CH_WEIGHT [4] = '{11, 59, 30, 10};

   logic [PIXEL_W-1:0]  pal_color [DEPTH];
   int unsigned         pal_count;
   logic [INDEX_W-1:0]  run_index;
   logic [LENGTH_W-1:0] run_len;
   logic                overflow_hit;
   logic [THRESH_W-1:0] threshold;
   logic [MAXC_W-1:0]   colour_limit;
   result_type          expected_q [$];

   // floor of the weighted squared channel distance over 100
   function automatic int unsigned weighted_distance(logic [PIXEL_W-1:0] a,
                                                     logic [PIXEL_W-1:0] b);
      int unsigned sum;
      int unsigned diff;
      sum = 0;
      for (int c = 0; c < 4; c++) begin
         diff = (a[8*c +: 8] > b[8*c +: 8]) ? a[8*c +: 8] - b[8*c +: 8]
                                            : b[8*c +: 8] - a[8*c +: 8];
         sum += CH_WEIGHT[c] * diff * diff;
      end
      return sum / 100;
   endfunction

   function automatic void push_result(kind_type k, logic [INDEX_W-1:0] i,
                                       logic [LENGTH_W-1:0] l, logic [PIXEL_W-1:0] c);
      result_type r;
      r.kind   = k;
      r.index  = i;
      r.length = l;
      r.color  = c;
      r.last   = 1'b0;
      expected_q = {expected_q, r};
   endfunction

   task automatic quantize_pixel(input logic [PIXEL_W-1:0] color, input logic last_px);
      int unsigned best;
      int unsigned d;
      int unsigned idx;
      int unsigned limit;
      int          queued;
      logic        halted;
      queued = expected_q.size();
      halted = overflow_hit;
      if (overflow_hit) begin
         push_result(KIND_OVERFLOW, '0, '0, '0);
      end else begin
         best = FAR_DISTANCE;
         idx  = 0;
         for (int i = 0; i < pal_count; i++) begin
            d = weighted_distance(color, pal_color[i]);
            // ties go to the later entry
            if (d <= best) begin
               best = d;
               idx  = i;
            end
         end
         limit = (colour_limit < DEPTH) ? colour_limit : DEPTH;
         if (best >= threshold) begin
            if (pal_count + 1 > limit) begin
               overflow_hit = 1'b1;
               halted       = 1'b1;
               push_result(KIND_OVERFLOW, '0, '0, '0);
            end else begin
               idx = pal_count;
               pal_color[idx] = color;
               pal_count++;
               push_result(KIND_ENTRY, INDEX_W'(idx), '0, color);
            end
         end
         if (!halted) begin
            if (run_len != 0 && idx == run_index && run_len < RUN_MAX) begin
               run_len++;
            end else begin
               if (run_len != 0) push_result(KIND_RUN, run_index, run_len, '0);
               run_index = INDEX_W'(idx);
               run_len   = 1;
            end
            if (last_px) begin
               push_result(KIND_RUN, run_index, run_len, '0);
               run_len = 0;
            end
         end
      end
      if (expected_q.size() > queued) expected_q[$].last = 1'b1;
   endtask

   always @(posedge clock) begin
      result_type want;
      result_type got;
      if (reset) begin
         pal_count    = 0;
         run_index    = '0;
         run_len      = '0;
         overflow_hit = 1'b0;
         threshold    = THRESH_RESET;
         colour_limit = MAXC_RESET;
         fail_count   = 0;
         expected_q.delete();
      end else begin
         if (csr_we) begin
            if (csr_addr == CSR_THRESHOLD) threshold = csr_wdata;
            else colour_limit = csr_wdata[MAXC_W-1:0];
         end
         // results seen at this edge belong to earlier requests
         if (rsp_tvalid && rsp_tready) begin
            got.kind   = kind_type'(rsp_tuser);
            got.index  = rsp_tdata[6:0];
            got.length = rsp_tdata[30:7];
            got.color  = rsp_tdata[62:31];
            got.last   = rsp_tlast;
            if (expected_q.size() == 0) begin
               fail_count++;
               $display("%0t unexpected result: kind=%0d index=%0d length=%0d color=%h last=%0b",
                        $time, got.kind, got.index, got.length, got.color, got.last);
            end else begin
               want = expected_q.pop_front();
               if (got.kind !== want.kind || got.index !== want.index ||
                   got.length !== want.length || got.color !== want.color ||
                   got.last !== want.last || rsp_tdata[63] !== 1'b0) begin
                  fail_count++;
                  $display("%0t mismatch: expected kind=%0d index=%0d length=%0d color=%h last=%0b",
                           $time, want.kind, want.index, want.length, want.color, want.last);
                  $display("%0t           actual kind=%0d index=%0d length=%0d color=%h last=%0b pad=%b",
                           $time, got.kind, got.index, got.length, got.color, got.last,
                           rsp_tdata[63]);
               end
            end
         end
         if (req_tvalid && req_tready) quantize_pixel(req_tdata, req_tlast);
      end
      pending_results = expected_q.size();
      palette_size    = pal_count;
   end

endmodule

// ----- tb/tb_top.sv -----
// Top of the testbench for adaptive_palette_quantizer_rle_unit.
// Drives pixel requests, CSR writes and result back-pressure; apq_rle_checker does the checking.
// Depends on apq_rle_pkg, apq_rle_checker and the unit itself.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import apq_rle_pkg::*;

   localparam int SETTLE_CYCLES = 200;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [PIXEL_W-1:0]    req_tdata;
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [KIND_W-1:0]     rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_we;
   logic                  csr_addr;
   logic [THRESH_W-1:0]   csr_wdata;
   logic                  req_taken;
   logic                  no_stall;
   int                    fail_count;
   int                    pending_results;
   int                    palette_size;
   logic [PIXEL_W-1:0]    entry_pool [$];

   adaptive_palette_quantizer_rle_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   apq_rle_checker scoreboard (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .pending_results (pending_results),
      .palette_size    (palette_size)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   always @(posedge clock) req_taken <= req_tvalid && req_tready;

   // result back-pressure: random stall and ready bursts, steady ready at the end
   initial begin
      rsp_tready = 1'b0;
      forever begin
         if (no_stall) begin
            rsp_tready <= 1'b1;
            @(negedge clock);
         end else if ($urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(negedge clock);
         end
      end
   end

   initial begin
      #1500000;
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic send_pixel(input logic [PIXEL_W-1:0] color, input logic last_px);
      int size_before;
      if (!no_stall && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      size_before = palette_size;
      req_tvalid <= 1'b1;
      req_tdata  <= color;
      req_tlast  <= last_px;
      do @(negedge clock); while (!req_taken);
      // remember colours that became palette entries
      if (palette_size > size_before) entry_pool = {entry_pool, color};
   endtask

   // hold off until every result is in and the unit has finished any silent request
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type addr, input logic [THRESH_W-1:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // mostly repeats and palette copies to build runs; fresh colours only while room remains
   task automatic random_pixels(input int count, input int room, input int calm_tail);
      logic [PIXEL_W-1:0] color;
      logic [PIXEL_W-1:0] prev;
      int                 pick;
      prev = '0;
      for (int k = 0; k < count; k++) begin
         if (k == count - calm_tail) no_stall = 1'b1;
         pick = $urandom_range(0, 99);
         if (k > 0 && pick < 40) begin
            color = prev;
         end else if (pick < 70 || palette_size >= room) begin
            color = entry_pool[$urandom_range(0, entry_pool.size() - 1)];
         end else if (pick < 85) begin
            color = entry_pool[$urandom_range(0, entry_pool.size() - 1)] ^
                    ($urandom() & 32'h0707_0707);
         end else begin
            color = $urandom();
         end
         send_pixel(color, $urandom_range(0, 11) == 0);
         prev = color;
      end
   endtask

   initial begin
      reset      = 1'b1;
      no_stall   = 1'b0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      csr_we     = 1'b0;
      csr_addr   = CSR_THRESHOLD;
      csr_wdata  = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: first pixel, extension, run close, flushes, three results at once
      send_pixel(32'h0000_0000, 1'b0);
      send_pixel(32'h0000_0000, 1'b0);
      send_pixel(32'hFFFF_FFFF, 1'b0);
      send_pixel(32'hFFFF_FFFE, 1'b0);
      send_pixel(32'hFFFF_FFFF, 1'b1);
      send_pixel(32'h0000_0000, 1'b1);
      send_pixel(32'h8080_8080, 1'b1);
      send_pixel(32'h1020_3040, 1'b0);
      send_pixel(32'h7F00_0000, 1'b1);
      drain();

      // low threshold: an equal distance to two entries picks the later one
      write_csr(CSR_THRESHOLD, 17'd100);
      write_csr(CSR_MAX_COLORS, 17'd128);
      send_pixel(32'h0000_0028, 1'b0);
      send_pixel(32'h0000_0014, 1'b0);
      random_pixels(150, 100, 0);
      drain();

      // highest threshold: nothing new can enter, long runs
      write_csr(CSR_THRESHOLD, 17'd100000);
      random_pixels(120, 100, 0);
      drain();

      // zero threshold: every pixel is a new entry, duplicates included
      write_csr(CSR_THRESHOLD, 17'd0);
      send_pixel(32'h0000_0000, 1'b0);
      send_pixel(32'hFFFF_FFFF, 1'b1);
      send_pixel(32'h0102_0304, 1'b0);
      send_pixel(32'h0000_0000, 1'b1);
      drain();

      write_csr(CSR_THRESHOLD, THRESH_W'($urandom_range(50, 3000)));
      write_csr(CSR_MAX_COLORS, 17'd127);
      random_pixels(180, 120, 40);
      drain();

      // smallest colour limit: overflow, then sticky error on every request
      write_csr(CSR_MAX_COLORS, 17'd1);
      write_csr(CSR_THRESHOLD, 17'd0);
      send_pixel(32'h1234_5678, 1'b0);
      send_pixel(32'hABCD_EF01, 1'b1);
      send_pixel(32'h0000_0000, 1'b0);
      drain();

      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- adaptive_palette_quantizer_rle_unit.f -----
hdl/apq_rle_pkg.sv
hdl/adaptive_palette_quantizer_rle_unit.sv
tb/apq_rle_checker.sv
tb/tb_top.sv
